// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion macros shared by the encoder rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define PPATE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define PPATE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PPATE_ASSERT(lbl, clk, rstn, prop)
`define PPATE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/ppate_pkg.sv
// ----------------------------------------------------------------------------
// ppate_pkg
// types, token table and constants of the truecolor half-block encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppate_pkg;

    localparam int POS_W = 5;

    localparam logic [POS_W-1:0] POS_ESC    = 5'd0;
    localparam logic [POS_W-1:0] POS_GLYPH0 = 5'd24;
    localparam logic [POS_W-1:0] POS_GLYPH2 = 5'd26;
    localparam logic [POS_W-1:0] POS_NL     = 5'd27;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef struct packed {
        logic [7:0] upper_red;
        logic [7:0] upper_green;
        logic [7:0] upper_blue;
        logic [7:0] upper_alpha;
        logic [7:0] lower_red;
        logic [7:0] lower_green;
        logic [7:0] lower_blue;
        logic [7:0] lower_alpha;
        logic       row_end;
        logic       frame_end;
    } ppate_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } ppate_out_t;

    typedef enum logic [1:0] {
        PLACE_HUND = 2'd0,
        PLACE_TENS = 2'd1,
        PLACE_ONES = 2'd2
    } place_t;

    typedef enum logic {
        TOK_LIT = 1'b0,
        TOK_NUM = 1'b1
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] lit;
        logic [2:0] chan;
    } tok_t;

    typedef struct packed {
        logic [3:0] digit;
        logic [6:0] rem;
        place_t     next_place;
        logic       done;
    } digit_res_t;

    function automatic tok_t tok_info(input logic [POS_W-1:0] pos);
        tok_t t;
        t.kind = TOK_LIT;
        t.lit  = 8'h00;
        t.chan = 3'd0;
        unique case (pos)
            5'd0:  t.lit = 8'h1B;
            5'd1:  t.lit = 8'h5B;
            5'd2:  t.lit = 8'h33;
            5'd3:  t.lit = 8'h38;
            5'd4:  t.lit = 8'h3B;
            5'd5:  t.lit = 8'h32;
            5'd6:  t.lit = 8'h3B;
            5'd7:  begin t.kind = TOK_NUM; t.chan = 3'd0; end
            5'd8:  t.lit = 8'h3B;
            5'd9:  begin t.kind = TOK_NUM; t.chan = 3'd1; end
            5'd10: t.lit = 8'h3B;
            5'd11: begin t.kind = TOK_NUM; t.chan = 3'd2; end
            5'd12: t.lit = 8'h3B;
            5'd13: t.lit = 8'h34;
            5'd14: t.lit = 8'h38;
            5'd15: t.lit = 8'h3B;
            5'd16: t.lit = 8'h32;
            5'd17: t.lit = 8'h3B;
            5'd18: begin t.kind = TOK_NUM; t.chan = 3'd4; end
            5'd19: t.lit = 8'h3B;
            5'd20: begin t.kind = TOK_NUM; t.chan = 3'd5; end
            5'd21: t.lit = 8'h3B;
            5'd22: begin t.kind = TOK_NUM; t.chan = 3'd6; end
            5'd23: t.lit = 8'h6D;
            5'd24: t.lit = 8'hE2;
            5'd25: t.lit = 8'h96;
            5'd26: t.lit = 8'h80;
            5'd27: t.lit = 8'h0A;
            default: t.lit = 8'h00;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pixel_pair_ansi_truecolor_encoder_unit.sv
// registered output; a new pair is accepted only after the current pair's last byte
// throughput: one byte per cycle unless m_ready stalls, 3 to 40 bytes per pair
// the byte sequencer walks a fixed token list and feeds one shared digit unit
// aresetn is synchronous active low: idle, no output, previous pair zero, row start set
// ----------------------------------------------------------------------------
// pixel_pair_ansi_truecolor_encoder_unit
// encodes vertical pixel pairs as truecolor escape runs and half-block glyphs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module pixel_pair_ansi_truecolor_encoder_unit
    import ppate_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire ppate_in_t s_payload,
    output logic      m_valid,
    input  wire logic m_ready,
    output ppate_out_t m_payload
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [63:0]      pair_reg, pair_next;
    logic             row_start_reg, row_start_next;
    logic             nl_reg, nl_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    place_t           place_reg, place_next;
    logic [6:0]       rem_reg, rem_next;
    logic             m_valid_reg, m_valid_next;
    ppate_out_t       m_payload_reg, m_payload_next;

    logic       s_fire;
    logic       advance;
    logic       esc_need;
    logic [63:0] in_pair;
    tok_t       tok;
    logic [7:0] chan_val;
    logic [7:0] digit_in;
    digit_res_t dres;
    logic       last_byte;

    assign in_pair = {s_payload.lower_alpha, s_payload.lower_blue, s_payload.lower_green,
                      s_payload.lower_red, s_payload.upper_alpha, s_payload.upper_blue,
                      s_payload.upper_green, s_payload.upper_red};

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign esc_need = row_start_reg || (in_pair != pair_reg);
    assign advance  = !m_valid_reg || m_ready;

    assign tok = tok_info(pos_reg);

    always_comb begin
        unique case (tok.chan)
            3'd0:    chan_val = pair_reg[7:0];
            3'd1:    chan_val = pair_reg[15:8];
            3'd2:    chan_val = pair_reg[23:16];
            3'd3:    chan_val = pair_reg[31:24];
            3'd4:    chan_val = pair_reg[39:32];
            3'd5:    chan_val = pair_reg[47:40];
            3'd6:    chan_val = pair_reg[55:48];
            default: chan_val = pair_reg[63:56];
        endcase
    end

    assign digit_in = (place_reg == PLACE_HUND) ? chan_val : {1'b0, rem_reg};

    ppate_digit u_digit (
        .val   (digit_in),
        .place (place_reg),
        .res   (dres)
    );

    assign last_byte = (pos_reg == POS_NL) || (pos_reg == POS_GLYPH2 && !nl_reg);

    always_comb begin
        state_next     = state_reg;
        pair_next      = pair_reg;
        row_start_next = row_start_reg;
        nl_next        = nl_reg;
        pos_next       = pos_reg;
        place_next     = place_reg;
        rem_next       = rem_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next     = ST_EMIT;
                    pair_next      = in_pair;
                    row_start_next = s_payload.row_end || s_payload.frame_end;
                    nl_next        = s_payload.row_end && !s_payload.frame_end;
                    pos_next       = esc_need ? POS_ESC : POS_GLYPH0;
                    place_next     = PLACE_HUND;
                end
            end
            ST_EMIT: begin
                if (advance) begin
                    m_valid_next            = 1'b1;
                    m_payload_next.run_last = last_byte;
                    if (tok.kind == TOK_NUM) begin
                        m_payload_next.out_byte = ASCII_ZERO + 8'(dres.digit);
                        place_next              = dres.next_place;
                        rem_next                = dres.rem;
                        if (dres.done) begin
                            pos_next = pos_reg + 5'd1;
                        end
                    end else begin
                        m_payload_next.out_byte = tok.lit;
                        place_next              = PLACE_HUND;
                        pos_next                = pos_reg + 5'd1;
                    end
                    if (last_byte) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pair_reg      <= '0;
            row_start_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
            pos_reg       <= POS_ESC;
            place_reg     <= PLACE_HUND;
        end else begin
            state_reg     <= state_next;
            pair_reg      <= pair_next;
            row_start_reg <= row_start_next;
            m_valid_reg   <= m_valid_next;
            pos_reg       <= pos_next;
            place_reg     <= place_next;
        end
    end

    always_ff @(posedge aclk) begin
        nl_reg        <= nl_next;
        rem_reg       <= rem_next;
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `PPATE_ASSERT(a_pos_range, aclk, aresetn, state_reg != ST_EMIT || pos_reg <= POS_NL)
    `PPATE_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, state_reg == ST_EMIT && advance && last_byte, state_reg == ST_IDLE && m_valid && m_payload.run_last)
    `PPATE_ASSERT_NEXT(a_skip_escape, aclk, aresetn, s_fire && !esc_need, pos_reg == POS_GLYPH0)
    `PPATE_ASSERT_NEXT(a_frame_row_start, aclk, aresetn, s_fire && s_payload.frame_end, row_start_reg && !nl_reg)

endmodule

`default_nettype wire

// File: rtl/ppate_digit.sv
// ----------------------------------------------------------------------------
// ppate_digit
// shared decimal digit unit: one digit per step, leading zeros skipped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppate_digit
    import ppate_pkg::*;
(
    input  wire logic [7:0] val,
    input  wire place_t     place,
    output digit_res_t      res
);

    logic [1:0]  hund;
    logic [7:0]  hund_sub;
    logic [7:0]  hund_rem;
    logic [6:0]  low7;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_sub;

    always_comb begin
        if (val >= 8'd200) begin
            hund     = 2'd2;
            hund_sub = 8'd200;
        end else if (val >= 8'd100) begin
            hund     = 2'd1;
            hund_sub = 8'd100;
        end else begin
            hund     = 2'd0;
            hund_sub = 8'd0;
        end
        hund_rem = val - hund_sub;
    end

    // divide by ten via reciprocal, exact below one hundred
    assign low7     = val[6:0];
    assign prod     = 15'(low7) * 15'd205;
    assign tens     = prod[14:11];
    assign tens_sub = 7'(tens) * 7'd10;

    always_comb begin
        res = '0;
        priority if (place == PLACE_HUND && val >= 8'd100) begin
            res.digit      = {2'b00, hund};
            res.rem        = hund_rem[6:0];
            res.next_place = PLACE_TENS;
            res.done       = 1'b0;
        end else if (place == PLACE_TENS || (place == PLACE_HUND && val >= 8'd10)) begin
            res.digit      = tens;
            res.rem        = low7 - tens_sub;
            res.next_place = PLACE_ONES;
            res.done       = 1'b0;
        end else begin
            res.digit      = val[3:0];
            res.rem        = 7'd0;
            res.next_place = PLACE_HUND;
            res.done       = 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the truecolor half-block encoder, random gaps and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ppate_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_PAIRS = 480;
    localparam int HOLD_AT      = 600;
    localparam int LONG_HOLD    = 500;
    localparam int TAIL_CYCLES  = 50;
    localparam int CYCLE_LIMIT  = 3000000;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] HALF_B0 = 8'hE2;
    localparam logic [7:0] HALF_B1 = 8'h96;
    localparam logic [7:0] HALF_B2 = 8'h80;

    typedef struct {
        ppate_in_t px;
        bit        drain_first;
    } pair_txn_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    ppate_in_t  s_payload = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    ppate_out_t m_payload;

    pair_txn_t  pixel_pairs_q[$];
    ppate_out_t expected_text_q[$];

    logic [63:0] last_pair = '0;
    logic        at_row_start = 1'b1;

    int pairs_sent = 0;
    int bytes_seen = 0;
    int error_count = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int cycle_count = 0;

    pixel_pair_ansi_truecolor_encoder_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #CLK_HALF aclk = ~aclk;

    // expected byte stream

    function automatic void push_char(input logic [7:0] c);
        ppate_out_t r;
        r.out_byte = c;
        r.run_last = 1'b0;
        expected_text_q.push_back(r);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i]);
        end
    endfunction

    function automatic void push_decimal(input logic [7:0] v);
        if (v >= 8'd100) begin
            push_char(ASCII_ZERO + v / 8'd100);
        end
        if (v >= 8'd10) begin
            push_char(ASCII_ZERO + (v / 8'd10) % 8'd10);
        end
        push_char(ASCII_ZERO + v % 8'd10);
    endfunction

    function automatic void encode_pair(input ppate_in_t px);
        logic [63:0] chans;
        chans = {px.upper_red, px.upper_green, px.upper_blue, px.upper_alpha,
                 px.lower_red, px.lower_green, px.lower_blue, px.lower_alpha};
        if (at_row_start || chans != last_pair) begin
            push_char(CH_ESC);
            push_text("[38;2;");
            push_decimal(px.upper_red);
            push_char(CH_SEMI);
            push_decimal(px.upper_green);
            push_char(CH_SEMI);
            push_decimal(px.upper_blue);
            push_text(";48;2;");
            push_decimal(px.lower_red);
            push_char(CH_SEMI);
            push_decimal(px.lower_green);
            push_char(CH_SEMI);
            push_decimal(px.lower_blue);
            push_char(CH_M);
        end
        push_char(HALF_B0);
        push_char(HALF_B1);
        push_char(HALF_B2);
        if (px.row_end && !px.frame_end) begin
            push_char(CH_LF);
        end
        last_pair = chans;
        at_row_start = px.row_end || px.frame_end;
        expected_text_q[expected_text_q.size() - 1].run_last = 1'b1;
    endfunction

    // stimulus helpers

    function automatic void add_pair(input logic [63:0] ch, input logic re,
                                     input logic fe, input bit drain);
        pair_txn_t t;
        t.px = ppate_in_t'({ch, re, fe});
        t.drain_first = drain;
        pixel_pairs_q.push_back(t);
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            2: return $urandom_range(0, 1) ? 8'd9 : 8'd10;
            3: return $urandom_range(0, 1) ? 8'd99 : 8'd100;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [63:0] pick_pair();
        logic [63:0] ch;
        for (int k = 0; k < 8; k++) begin
            ch[8*k +: 8] = pick_level();
        end
        return ch;
    endfunction

    // input driver

    always @(posedge aclk) begin
        pair_txn_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                encode_pair(s_payload);
                pairs_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pixel_pairs_q.size() != 0 &&
                             !(pixel_pairs_q[0].drain_first && expected_text_q.size() != 0)) begin
                    nxt = pixel_pairs_q.pop_front();
                    s_payload <= nxt.px;
                    s_valid <= 1'b1;
                    send_gap = ((pairs_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor

    always @(posedge aclk) begin
        ppate_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                bytes_seen++;
                if (expected_text_q.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, got %02h last %0b",
                             $time, m_payload.out_byte, m_payload.run_last);
                    error_count++;
                end else begin
                    want = expected_text_q.pop_front();
                    if (m_payload.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte mismatch, expected %02h, got %02h",
                                 $time, want.out_byte, m_payload.out_byte);
                        error_count++;
                    end
                    if (m_payload.run_last !== want.run_last) begin
                        $display("%0t: run_last mismatch, expected %0b, got %0b",
                                 $time, want.run_last, m_payload.run_last);
                        error_count++;
                    end
                end
                recv_stall = ((bytes_seen / 150) % 3 == 2) ? 0 : $urandom_range(0, 19);
                if (bytes_seen == HOLD_AT) begin
                    recv_stall = LONG_HOLD;
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int          row_len;
        int          rand_pairs;
        int          pick;
        logic [63:0] cur;
        logic        re;
        logic        fe;

        // single digits, repeat without escape, alpha-only changes
        add_pair(64'h0, 1'b0, 1'b0, 1'b0);
        add_pair(64'h0, 1'b0, 1'b0, 1'b0);
        add_pair(64'h00000001_00000000, 1'b0, 1'b0, 1'b0);
        add_pair(64'h00000001_00000001, 1'b0, 1'b0, 1'b0);
        // three digits, row end newline, identical pair at row start
        add_pair({8{8'hFF}}, 1'b1, 1'b0, 1'b0);
        add_pair({8{8'hFF}}, 1'b0, 1'b0, 1'b0);
        add_pair({8{8'hFF}}, 1'b0, 1'b0, 1'b0);
        add_pair({8'd9, 8'd10, 8'd99, 8'd100, 8'd199, 8'd200, 8'd255, 8'd0},
                 1'b0, 1'b0, 1'b0);
        add_pair({8'd100, 8'd99, 8'd10, 8'd9, 8'd0, 8'd1, 8'd254, 8'd128},
                 1'b0, 1'b0, 1'b0);
        // frame end without row end, then same pair at new row
        add_pair({8'd100, 8'd99, 8'd10, 8'd9, 8'd0, 8'd1, 8'd254, 8'd128},
                 1'b0, 1'b1, 1'b0);
        add_pair({8'd100, 8'd99, 8'd10, 8'd9, 8'd0, 8'd1, 8'd254, 8'd128},
                 1'b0, 1'b0, 1'b0);
        // row and frame end together drop the newline
        add_pair(64'hAA55AA55_55AA55AA, 1'b1, 1'b1, 1'b0);
        add_pair(64'h55AA55AA_AA55AA55, 1'b0, 1'b0, 1'b0);
        add_pair(64'h55AA55AA_AA55AA55, 1'b1, 1'b0, 1'b0);
        add_pair(64'h01020304_05060708, 1'b1, 1'b1, 1'b0);
        add_pair(64'hFF00FF00_00FF00FF, 1'b1, 1'b0, 1'b0);
        add_pair(64'h80402010_08040201, 1'b0, 1'b1, 1'b1);

        // random rows, mostly well formed with runs of repeated pairs
        rand_pairs = 0;
        cur = pick_pair();
        while (rand_pairs < RANDOM_PAIRS) begin
            row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
            for (int col = 0; col < row_len; col++) begin
                pick = $urandom_range(0, 9);
                if (pick >= 6) begin
                    cur = pick_pair();
                end else if (pick >= 4) begin
                    cur[8*$urandom_range(0, 7) +: 8] = pick_level();
                end
                re = (col == row_len - 1);
                fe = re && ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 19) == 0) begin
                    re = 1'($urandom_range(0, 1));
                    fe = 1'($urandom_range(0, 1));
                end
                add_pair(cur, re, fe, rand_pairs == RANDOM_PAIRS / 2);
                rand_pairs++;
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pixel_pairs_q.size() != 0 || s_valid) @(posedge aclk);
        while (expected_text_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
